// ----- sv/hufd_pkg.sv -----
`timescale 1ns / 1ps

package hufd_pkg;

    // field widths
    localparam int IDX_W          = 9;
    localparam int SYM_W          = 8;
    localparam int BITS_PER_BYTE  = 8;
    localparam int BIT_CNT_W      = $clog2(BITS_PER_BYTE + 1);

    // stream payload widths
    localparam int S_TDATA_W      = 48;
    localparam int M_TDATA_W      = SYM_W;

    // defaults and queue sizing
    localparam int NODE_COUNT_DEF = 512;
    localparam int QUEUE_DEPTH    = 4;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [SYM_W-1:0] sym_t;

    // child marker for a missing branch
    localparam idx_t NO_CHILD   = '1;
    localparam idx_t ROOT_RESET = 9'd510;

    // one tree node, packed as left, right, leaf flag, symbol from the top bit down
    typedef struct packed {
        idx_t left;
        idx_t right;
        logic leaf;
        sym_t symbol;
    } node_entry_t;

    typedef enum logic {
        OP_NODE_WRITE = 1'b0,
        OP_DECODE     = 1'b1
    } op_t;

    // classified command passed from front to back
    typedef struct packed {
        op_t         op;
        idx_t        node_index;
        node_entry_t entry;
        sym_t        code_byte;
    } queue_item_t;

    // one decoded result before the last flag is known
    typedef struct packed {
        logic valid;
        sym_t symbol;
        logic error;
    } result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_REFRESH_RD,
        BK_REFRESH_LD,
        BK_DECODE,
        BK_FLUSH
    } back_state_t;

endpackage

// ----- sv/huffman_tree_decoder_top.sv -----
`timescale 1ns / 1ps

// Huffman decoder walking a code tree held in an on-chip node table.
// Input stream s_*: s_tuser selects the command (0 node write, 1 decode byte).
//   A node write stores left/right child, leaf flag and symbol at node_index;
//   a decode item brings one code byte, walked msb first, 0 left and 1 right.
// Output stream m_*: one item per leaf reached or missing or out-of-range child taken;
//   m_tuser marks a missing or out-of-range child (symbol 0), m_tlast the final item of a byte.
//   A byte that ends inside a code gives no item; the walk resumes next byte.
// Config channel cfg_*: writes the root node index and restarts the walk there;
//   the root entry is then reloaded from the table by a read and a load state.
// Order of work: a node write is taken straight from the idle state; a decode byte
//   passes a load, 8 walk steps plus the final resolve and a flush of the held
//   item, with at most one node read per code bit on the table's single read port.
//   The back end takes no new item until a byte is flushed. A byte's first item
//   passes the input stage, queue, load, a walk step, the resolve, the hold
//   register and the output register; its last item is sent from the flush.
// Reset: root and walk position go to node 510; the table is not cleared.
// A stalled receiver holds the output register and freezes the walk; the input
//   stage and the 4-entry queue keep taking items until full.
module huffman_tree_decoder_top #(
    parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // node_index[8:0], left_child[17:9], right_child[26:18], node_is_leaf[27],
    // leaf_symbol[35:28], code_byte[43:36], zero fill[47:44]
    input  logic [hufd_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic                           s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // symbol[7:0]
    output logic [hufd_pkg::M_TDATA_W-1:0] m_tdata,
    // error
    output logic                           m_tuser,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  hufd_pkg::idx_t                 cfg_data
);
    import hufd_pkg::*;

    logic        fq_valid;
    logic        fq_ready;
    queue_item_t fq_item;
    logic        qb_valid;
    logic        qb_ready;
    queue_item_t qb_item;

    // accept and classify
    hufd_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    // command queue between front and back
    hufd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    // table writes and tree walk
    hufd_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_item    (qb_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- sv/hufd_front.sv -----
`timescale 1ns / 1ps

module hufd_front #(
    parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hufd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    output logic                           q_valid,
    input  logic                           q_ready,
    output hufd_pkg::queue_item_t          q_item
);
    import hufd_pkg::*;

    logic        hold_valid_reg;
    logic        hold_valid_next;
    queue_item_t item_reg;
    queue_item_t item_next;
    queue_item_t item_in;
    logic        in_range;
    logic        keep;
    logic        accept;

    // unpack the input item
    always_comb
    begin
        item_in.op           = op_t'(s_tuser);
        item_in.node_index   = s_tdata[8:0];
        item_in.entry.left   = s_tdata[17:9];
        item_in.entry.right  = s_tdata[26:18];
        item_in.entry.leaf   = s_tdata[27];
        item_in.entry.symbol = s_tdata[35:28];
        item_in.code_byte    = s_tdata[43:36];
    end

    // node writes outside the table are dropped here
    assign in_range = ({23'd0, item_in.node_index} < 32'(NODE_COUNT));
    assign keep     = (item_in.op == OP_DECODE) || in_range;

    assign s_tready = !hold_valid_reg || q_ready;
    assign accept   = s_tvalid && s_tready;

    // input stage next values
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        item_next       = item_reg;
        if (accept)
        begin
            hold_valid_next = keep;
            item_next       = item_in;
        end
        else if (q_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign q_valid = hold_valid_reg;
    assign q_item  = item_reg;

endmodule

// ----- sv/hufd_fifo.sv -----
`timescale 1ns / 1ps

module hufd_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  hufd_pkg::queue_item_t push_item,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output hufd_pkg::queue_item_t pop_item
);
    import hufd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    queue_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [PTR_W:0]     count_reg;
    logic [PTR_W:0]     count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != (PTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- sv/hufd_back.sv -----
`timescale 1ns / 1ps

module hufd_back #(
    parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  hufd_pkg::idx_t                 cfg_data,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  hufd_pkg::queue_item_t          q_item,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hufd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import hufd_pkg::*;

    localparam int MEM_DEPTH = (NODE_COUNT < (1 << IDX_W)) ? NODE_COUNT : (1 << IDX_W);
    localparam int AW        = $clog2(MEM_DEPTH);

    // node table
    node_entry_t            node_mem [MEM_DEPTH];
    node_entry_t            rdata_reg;

    back_state_t            state_reg;
    back_state_t            state_next;

    idx_t                   root_reg;
    idx_t                   root_next;
    node_entry_t            root_entry_reg;
    node_entry_t            root_entry_next;
    idx_t                   cur_idx_reg;
    idx_t                   cur_idx_next;
    node_entry_t            cur_entry_reg;
    node_entry_t            cur_entry_next;
    logic                   refresh_pend_reg;
    logic                   refresh_pend_next;

    sym_t                   byte_reg;
    sym_t                   byte_next;
    logic [BIT_CNT_W-1:0]   issue_left_reg;
    logic [BIT_CNT_W-1:0]   issue_left_next;
    logic                   pend_reg;
    logic                   pend_next;
    logic                   pend_err_reg;
    logic                   pend_err_next;
    idx_t                   pend_child_reg;
    idx_t                   pend_child_next;

    result_t                hold_reg;
    result_t                hold_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    sym_t                   out_symbol_reg;
    sym_t                   out_symbol_next;
    logic                   out_error_reg;
    logic                   out_error_next;
    logic                   out_last_reg;
    logic                   out_last_next;

    logic                   adv;
    logic                   p_restart;
    idx_t                   eff_idx;
    node_entry_t            eff_entry;
    result_t                res;
    idx_t                   child;
    logic                   child_bad;
    logic                   root_in_range;

    logic                   wr_en;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   load_byte;
    logic                   do_resolve;
    logic                   do_issue;
    logic                   push;
    logic                   push_last;

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid_reg || m_tready;

    // resolve the read issued by the last walk step and pick the node the next bit starts from
    always_comb
    begin
        p_restart  = pend_err_reg || rdata_reg.leaf;
        eff_idx    = cur_idx_reg;
        eff_entry  = cur_entry_reg;
        if (pend_reg)
        begin
            eff_idx   = p_restart ? root_reg : pend_child_reg;
            eff_entry = p_restart ? root_entry_reg : rdata_reg;
        end
        res.valid  = pend_reg && p_restart;
        res.error  = pend_err_reg;
        res.symbol = pend_err_reg ? '0 : rdata_reg.symbol;
    end

    // child selection by the next code bit
    assign child         = byte_reg[SYM_W-1] ? eff_entry.right : eff_entry.left;
    assign child_bad     = (child == NO_CHILD) || !({23'd0, child} < 32'(NODE_COUNT));
    assign root_in_range = ({23'd0, root_reg} < 32'(NODE_COUNT));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (refresh_pend_reg)
                begin
                    state_next = BK_REFRESH_RD;
                end
                else if (q_valid && (q_item.op == OP_DECODE))
                begin
                    state_next = BK_DECODE;
                end
            end
            BK_REFRESH_RD:
            begin
                state_next = BK_REFRESH_LD;
            end
            BK_REFRESH_LD:
            begin
                state_next = BK_IDLE;
            end
            BK_DECODE:
            begin
                if (adv && (issue_left_reg == '0))
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH:
            begin
                if (adv)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control outputs per state
    always_comb
    begin
        q_ready    = 1'b0;
        wr_en      = 1'b0;
        load_byte  = 1'b0;
        do_resolve = 1'b0;
        do_issue   = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = child[AW-1:0];
        push       = 1'b0;
        push_last  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_ready   = !refresh_pend_reg;
                wr_en     = q_ready && q_valid && (q_item.op == OP_NODE_WRITE);
                load_byte = q_ready && q_valid && (q_item.op == OP_DECODE);
            end
            BK_REFRESH_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = root_reg[AW-1:0];
            end
            BK_DECODE:
            begin
                if (adv)
                begin
                    do_resolve = pend_reg;
                    do_issue   = (issue_left_reg != '0);
                    rd_en      = do_issue && !child_bad;
                    push       = res.valid && hold_reg.valid;
                end
            end
            BK_FLUSH:
            begin
                push      = adv && hold_reg.valid;
                push_last = 1'b1;
            end
            default:
            begin
                q_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        root_next         = root_reg;
        root_entry_next   = root_entry_reg;
        cur_idx_next      = cur_idx_reg;
        cur_entry_next    = cur_entry_reg;
        refresh_pend_next = refresh_pend_reg;
        byte_next         = byte_reg;
        issue_left_next   = issue_left_reg;
        pend_next         = pend_reg;
        pend_err_next     = pend_err_reg;
        pend_child_next   = pend_child_reg;
        hold_next         = hold_reg;
        out_valid_next    = out_valid_reg;
        out_symbol_next   = out_symbol_reg;
        out_error_next    = out_error_reg;
        out_last_next     = out_last_reg;

        // root entry reload after a root change
        if (state_reg == BK_REFRESH_LD)
        begin
            root_entry_next   = root_in_range ? rdata_reg : '0;
            cur_entry_next    = root_in_range ? rdata_reg : '0;
            refresh_pend_next = 1'b0;
        end

        // node write keeps the cached entries coherent
        if (wr_en)
        begin
            if (q_item.node_index == root_reg)
            begin
                root_entry_next = q_item.entry;
            end
            if (q_item.node_index == cur_idx_reg)
            begin
                cur_entry_next = q_item.entry;
            end
        end

        // start of a code byte
        if (load_byte)
        begin
            byte_next       = q_item.code_byte;
            issue_left_next = BIT_CNT_W'(BITS_PER_BYTE);
            pend_next       = 1'b0;
        end

        // walk step
        if (do_resolve)
        begin
            cur_idx_next   = eff_idx;
            cur_entry_next = eff_entry;
        end
        if (state_reg == BK_DECODE && adv)
        begin
            if (do_issue)
            begin
                byte_next       = {byte_reg[SYM_W-2:0], 1'b0};
                issue_left_next = issue_left_reg - 1'b1;
                pend_next       = 1'b1;
                pend_err_next   = child_bad;
                pend_child_next = child;
            end
            else
            begin
                pend_next = 1'b0;
            end
            if (res.valid)
            begin
                hold_next = res;
            end
        end
        if (state_reg == BK_FLUSH && adv)
        begin
            hold_next.valid = 1'b0;
        end

        // output register
        if (push)
        begin
            out_valid_next  = 1'b1;
            out_symbol_next = hold_reg.symbol;
            out_error_next  = hold_reg.error;
            out_last_next   = push_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // root register write restarts the walk
        if (cfg_valid)
        begin
            root_next         = cfg_data;
            cur_idx_next      = cfg_data;
            refresh_pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            root_reg         <= ROOT_RESET;
            root_entry_reg   <= '0;
            cur_idx_reg      <= ROOT_RESET;
            cur_entry_reg    <= '0;
            refresh_pend_reg <= 1'b0;
            issue_left_reg   <= '0;
            pend_reg         <= 1'b0;
            hold_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            root_reg         <= root_next;
            root_entry_reg   <= root_entry_next;
            cur_idx_reg      <= cur_idx_next;
            cur_entry_reg    <= cur_entry_next;
            refresh_pend_reg <= refresh_pend_next;
            issue_left_reg   <= issue_left_next;
            pend_reg         <= pend_next;
            hold_reg         <= hold_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        pend_err_reg   <= pend_err_next;
        pend_child_reg <= pend_child_next;
        out_symbol_reg <= out_symbol_next;
        out_error_reg  <= out_error_next;
        out_last_reg   <= out_last_next;
    end

    // node memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[q_item.node_index[AW-1:0]] <= q_item.entry;
        end
        if (rd_en)
        begin
            rdata_reg <= node_mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_symbol_reg;
    assign m_tuser  = out_error_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- sv/hufd_checker.sv -----
`timescale 1ns / 1ps

module hufd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic [hufd_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           s_tuser,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [hufd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready
);
    import hufd_pkg::*;

    logic decode_seen_reg;

    // remembers that a decode item has been taken since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_seen_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready && (op_t'(s_tuser) == OP_DECODE))
        begin
            decode_seen_reg <= 1'b1;
        end
    end

    // stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output item changed while stalled");

    // a missing-child item carries symbol zero
    a_err_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == '0))
        else $error("error item with nonzero symbol");

    // no output item without a decode item before it
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> decode_seen_reg)
        else $error("output item without any decode item");

    // s_tdata is watched only by its parity, for unknown bits on accepted items
    logic unused_tdata;
    assign unused_tdata = ^s_tdata;

    a_tdata_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !$isunknown(unused_tdata))
        else $error("accepted input item with unknown data");

endmodule

bind huffman_tree_decoder_top hufd_checker u_hufd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import hufd_pkg::*;

    localparam int NODES       = NODE_COUNT_DEF;
    localparam int GAP_PCT     = 21;
    localparam int SETTLE      = 96;
    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_MAX  = 10;

    // one decoded symbol as it should leave the block
    typedef struct packed {
        sym_t symbol;
        logic error;
        logic last;
    } decoded_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    idx_t                 cfg_data  = '0;

    // shadow of the code tree and the walk position
    node_entry_t tree_mem [NODES];
    idx_t        walk_root = ROOT_RESET;
    idx_t        walk_node = ROOT_RESET;

    // items waiting to be sent and symbols waiting to come out
    queue_item_t pending_items [$];
    decoded_t    expected_syms [$];
    queue_item_t bus_item;
    int          pushed_count   = 0;
    int          accepted_count = 0;
    int          fail_count     = 0;
    int          idle_cycles    = 0;
    bit          no_gaps        = 1'b0;

    // nodes already written, so walks never touch an empty entry
    bit          node_written [NODES];
    idx_t        written_nodes [$];

    huffman_tree_decoder_top #(
        .NODE_COUNT (NODES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(99) < GAP_PCT);
    endfunction

    // update the tree shadow or walk one code byte, queueing its symbols
    task automatic apply_command(input queue_item_t it);
        decoded_t    found [BITS_PER_BYTE];
        node_entry_t here;
        node_entry_t next_node;
        idx_t        child;
        int          n;
        n = 0;
        if (it.op == OP_NODE_WRITE)
        begin
            tree_mem[it.node_index] = it.entry;
        end
        else
        begin
            for (int b = BITS_PER_BYTE - 1; b >= 0; b--)
            begin
                here  = tree_mem[walk_node];
                child = it.code_byte[b] ? here.right : here.left;
                if (child == NO_CHILD)
                begin
                    // missing branch: flag it and restart at the root
                    found[n]  = '{symbol: '0, error: 1'b1, last: 1'b0};
                    n++;
                    walk_node = walk_root;
                end
                else
                begin
                    next_node = tree_mem[child];
                    if (next_node.leaf)
                    begin
                        found[n]  = '{symbol: next_node.symbol, error: 1'b0, last: 1'b0};
                        n++;
                        walk_node = walk_root;
                    end
                    else
                    begin
                        walk_node = child;
                    end
                end
            end
            for (int i = 0; i < n; i++)
            begin
                found[i].last = (i == n - 1);
                expected_syms.push_back(found[i]);
            end
        end
    endtask

    function automatic queue_item_t random_item();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(queue_item_t)-1:0];
    endfunction

    task automatic add_node(input idx_t idx, input idx_t left, input idx_t right,
                            input logic leaf, input sym_t sym);
        queue_item_t it;
        it            = random_item();
        it.op         = OP_NODE_WRITE;
        it.node_index = idx;
        it.entry      = '{left: left, right: right, leaf: leaf, symbol: sym};
        pending_items.push_back(it);
        pushed_count++;
        if (!node_written[idx])
        begin
            node_written[idx] = 1'b1;
            written_nodes.push_back(idx);
        end
    endtask

    task automatic add_byte(input sym_t code);
        queue_item_t it;
        it           = random_item();
        it.op        = OP_DECODE;
        it.code_byte = code;
        pending_items.push_back(it);
        pushed_count++;
    endtask

    // child pointer: missing, self, or some node already written
    function automatic idx_t pick_child(input idx_t self_idx);
        int roll;
        roll = $urandom_range(99);
        if (roll < 15 || written_nodes.size() == 0)
            return NO_CHILD;
        if (roll < 22)
            return self_idx;
        return written_nodes[$urandom_range(written_nodes.size() - 1)];
    endfunction

    // proper code tree, built bottom up by merging random pairs
    task automatic build_code_tree(input int leaves, output idx_t top);
        idx_t level [$];
        bit   taken [NODES];
        idx_t a;
        idx_t b;
        idx_t n;
        int   k;
        for (int i = 0; i < leaves; i++)
        begin
            do n = idx_t'($urandom_range(NODES - 2)); while (taken[n]);
            taken[n] = 1'b1;
            add_node(n, pick_child(n), pick_child(n), 1'b1, sym_t'($urandom));
            level.push_back(n);
        end
        while (level.size() > 1)
        begin
            k = $urandom_range(level.size() - 1);
            a = level[k];
            level.delete(k);
            k = $urandom_range(level.size() - 1);
            b = level[k];
            level.delete(k);
            do n = idx_t'($urandom_range(NODES - 2)); while (taken[n]);
            taken[n] = 1'b1;
            add_node(n, a, b, 1'b0, sym_t'($urandom));
            level.push_back(n);
        end
        top = level[0];
    endtask

    task automatic wait_drained();
        while (accepted_count != pushed_count || expected_syms.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_root(input idx_t value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        walk_root = value;
        walk_node = value;
    endtask

    // input side: hold the item until taken, then maybe fetch the next
    always @(posedge clk or negedge rst_n)
    begin : item_driver
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_command(bus_item);
                accepted_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && !take_gap())
                begin
                    bus_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= bus_item.op;
                    s_tdata  <= {4'b0, bus_item.code_byte, bus_item.entry.symbol,
                                 bus_item.entry.leaf, bus_item.entry.right,
                                 bus_item.entry.left, bus_item.node_index};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: compare each symbol item with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : symbol_check
        decoded_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_syms.size() == 0)
                begin
                    if (fail_count < REPORT_MAX)
                        $display("unexpected item: symbol %h error %b last %b",
                                 m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = expected_syms.pop_front();
                    if (m_tdata !== want.symbol || m_tuser !== want.error ||
                        m_tlast !== want.last)
                    begin
                        if (fail_count < REPORT_MAX)
                            $display("mismatch: expected symbol %h error %b last %b, got %h %b %b",
                                     want.symbol, want.error, want.last,
                                     m_tdata, m_tuser, m_tlast);
                        fail_count++;
                    end
                end
            end
            m_tready <= !take_gap();
        end
    end

    // stop a hung run
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        idx_t tree_top;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // leaves 0 and 1, inner node 2 missing its right branch, root at reset index
        add_node(9'd0, NO_CHILD, NO_CHILD, 1'b1, 8'h00);
        add_node(9'd1, NO_CHILD, NO_CHILD, 1'b1, 8'hFF);
        add_node(9'd2, 9'd1, NO_CHILD, 1'b0, 8'h3C);
        add_node(ROOT_RESET, 9'd0, 9'd2, 1'b0, 8'hC3);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'hA5);
        add_byte(8'h80);
        // top index as root, itself a leaf whose children are still followed
        add_node(9'd511, 9'd0, NO_CHILD, 1'b1, 8'h5A);
        wait_drained();
        write_root(9'd511);
        add_byte(8'h55);
        // self loop: a zero byte ends inside a code with no item
        add_node(9'd3, 9'd3, 9'd1, 1'b0, 8'h77);
        wait_drained();
        write_root(9'd3);
        add_byte(8'h00);
        add_byte(8'h01);
        wait_drained();
        // lowest index as root, a leaf with both branches missing
        write_root(9'd0);
        add_byte(8'hFF);
        wait_drained();

        // random phases: proper trees and random node graphs
        for (int phase = 0; phase < 6; phase++)
        begin
            no_gaps = (phase == 2);
            if (phase == 1 || phase == 4)
            begin
                build_code_tree($urandom_range(2, 16), tree_top);
                wait_drained();
                write_root(tree_top);
                for (int i = 0; i < 60; i++)
                    add_byte(sym_t'($urandom));
            end
            else
            begin
                write_root(written_nodes[$urandom_range(written_nodes.size() - 1)]);
                for (int i = 0; i < 70; i++)
                begin
                    // hold the sender until every symbol is out
                    if (phase == 3 && i == 35)
                        wait_drained();
                    if ($urandom_range(99) < 35)
                    begin
                        tree_top = idx_t'($urandom_range(NODES - 1));
                        add_node(tree_top, pick_child(tree_top), pick_child(tree_top),
                                 $urandom_range(99) < 40, sym_t'($urandom));
                    end
                    else
                    begin
                        add_byte(sym_t'($urandom));
                    end
                end
            end
            wait_drained();
        end
        no_gaps = 1'b0;

        fail_count += expected_syms.size();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
